### hdl/pwlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear resistance lookup package
// Curve selector codes, breakpoint and resistance tables, and the constants
// of the divide-by-fifty reciprocal used for rounding.
// ----------------------------------------------------------------------------
package pwlr_pkg;

	localparam int TABLE_POINTS = 8;
	localparam int SEG_WIDTH    = 160;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_MIXED = 2'd0;
	localparam cmd_t CMD_EMPTY = 2'd1;
	localparam cmd_t CMD_FULL  = 2'd2;
	localparam cmd_t CMD_NONE  = 2'd3;

	typedef logic [7:0]         tab_val_t;
	typedef logic [2:0]         seg_t;
	typedef logic signed [12:0] pos_t;

	localparam pos_t BREAK_POINT [TABLE_POINTS] = '{
		13'sd0, 13'sd160, 13'sd320, 13'sd480, 13'sd640, 13'sd800, 13'sd960, 13'sd1120
	};

	localparam tab_val_t MIXED_TAB [TABLE_POINTS] = '{
		8'd0, 8'd34, 8'd42, 8'd53, 8'd72, 8'd92, 8'd116, 8'd152
	};
	localparam tab_val_t EMPTY_TAB [TABLE_POINTS] = '{
		8'd0, 8'd45, 8'd54, 8'd67, 8'd92, 8'd118, 8'd148, 8'd198
	};
	localparam tab_val_t FULL_TAB [TABLE_POINTS] = '{
		8'd0, 8'd23, 8'd30, 8'd39, 8'd52, 8'd66, 8'd84, 8'd104
	};

	// Division by 50 is a multiply by ceil(2^26 / 50) and a shift; it is exact
	// for every dividend below 2^20.
	localparam int              RECIP_SHIFT = 26;
	localparam logic [20:0]     RECIP_50    = 21'd1342178;
	localparam logic [19:0]     ROUND_BIAS  = 20'd25;

	localparam logic signed [14:0] RES_MIN = -15'sd16384;
	localparam logic signed [14:0] RES_MAX = 15'sd16383;

	typedef struct packed {
		logic clamp;
		logic zero;
	} mode_t;

	function automatic tab_val_t tab_val(input cmd_t curve, input seg_t pt);
		tab_val_t v;
		case (curve)
			CMD_EMPTY: v = EMPTY_TAB[pt];
			CMD_FULL:  v = FULL_TAB[pt];
			default:   v = MIXED_TAB[pt];
		endcase
		return v;
	endfunction

endpackage

### hdl/piecewise_linear_resistance_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear resistance lookup
// Interpolates rolling resistance from train speed over one of three fixed
// eight-point curves, rounds to nearest and saturates to the output range.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  request   req_valid, req_stall   speed (12, signed), cmd (2)
//  result    res_valid, res_stall   resistance (15, signed)
//
// A new request is taken every cycle while req_stall is low; its result passes
// through an input register, a register after the segment multiply and the
// result register after the reciprocal multiply. Reset empties all three
// stages. A stalled result holds its stage, and the stages behind it fill
// before req_stall rises.
module piecewise_linear_resistance_lookup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic signed [11:0]   speed,
	input  pwlr_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic signed [14:0]   resistance
);
	import pwlr_pkg::*;

	logic               valid_s1, valid_s2;
	logic               en1, en2, en_out;
	logic signed [11:0] speed_s1;
	cmd_t               cmd_s1;
	logic signed [19:0] m_s2;
	mode_t              mode_s2;
	logic signed [14:0] resistance_q;
	logic               res_valid_q;

	assign en_out    = !res_valid_q || !res_stall;
	assign en2       = !valid_s2 || en_out;
	assign en1       = !valid_s1 || en2;
	assign req_stall = !en1;
	assign res_valid = res_valid_q;
	assign resistance = resistance_q;

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			speed_s1 <= speed;
			cmd_s1   <= cmd;
		end
	end

	// Segment selection and linear term.
	pos_t               x;
	seg_t               seg;
	pos_t               d;
	tab_val_t           y0;
	tab_val_t           y1;
	logic [6:0]         dy;
	logic [14:0]        ybase;
	logic signed [19:0] prod;
	logic signed [19:0] m;
	mode_t              mode;

	always_comb begin
		if (cmd_s1 == CMD_MIXED) begin
			x = speed_s1[11] ? -13'(speed_s1) : 13'(speed_s1);
		end else if (speed_s1 == 12'sd0) begin
			x = 13'(SEG_WIDTH);
		end else begin
			x = 13'(speed_s1);
		end
		seg = '0;
		for (int k = 1; k < TABLE_POINTS - 1; k++) begin
			if (x >= BREAK_POINT[3'(k)]) begin
				seg = 3'(k);
			end
		end
		d     = x - BREAK_POINT[seg];
		y0    = tab_val(cmd_s1, seg);
		y1    = tab_val(cmd_s1, seg + 3'd1);
		dy    = 7'(y1 - y0);
		ybase = 15'(32'(y0) * SEG_WIDTH);
		prod  = 20'(d) * $signed({13'd0, dy});
		m     = prod + $signed({5'd0, ybase});
		mode.clamp = (cmd_s1 == CMD_MIXED);
		mode.zero  = (cmd_s1 == CMD_NONE);
	end

	// Stage 2: register after the segment multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			m_s2    <= m;
			mode_s2 <= mode;
		end
	end

	// Rounded division by 25 of four times the linear term, then zeroing or saturation.
	logic               neg;
	logic [19:0]        mag_full;
	logic [19:0]        t;
	logic [40:0]        qprod;
	logic [14:0]        q;
	logic [15:0]        q_neg;
	logic signed [14:0] r;

	always_comb begin
		neg      = m_s2[19];
		mag_full = neg ? 20'(-m_s2) : 20'(m_s2);
		t        = {mag_full[16:0], 3'b000} + ROUND_BIAS;
		qprod    = 41'(t) * 41'(RECIP_50);
		q        = 15'(qprod >> RECIP_SHIFT);
		q_neg    = -{1'b0, q};
		if (mode_s2.zero || (mode_s2.clamp && neg)) begin
			r = '0;
		end else if (neg) begin
			r = ({1'b0, q} > 16'd16384) ? RES_MIN : $signed(q_neg[14:0]);
		end else begin
			r = q[14] ? RES_MAX : $signed(q);
		end
	end

	// Stage 3: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			resistance_q <= r;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && res_valid_q))
		else $error("request stalled while the pipeline has room");

	a_unused_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en_out && mode_s2.zero) |=> (resistance == 15'sd0))
		else $error("unused selector gave a nonzero result");

	a_mixed_not_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en_out && mode_s2.clamp) |=> !resistance[14])
		else $error("mixed curve result is negative");

endmodule
